// File: hdl/rlp_enc_pkg.sv
// ----------------------------------------------------------------------------
// rlp_enc_pkg
// Shared types, codes and helpers of the RLP item encoder.
// ----------------------------------------------------------------------------
package rlp_enc_pkg;

   typedef enum logic [2:0] {
      OP_STR_HDR  = 3'd0,
      OP_PAYLOAD  = 3'd1,
      OP_UINT64   = 3'd2,
      OP_UINT256  = 3'd3,
      OP_LIST_HDR = 3'd4
   } op_type;

   localparam logic [7:0]  SINGLE_MAX = 8'h7f;
   localparam logic [63:0] SHORT_MAX  = 64'd55;
   localparam logic [7:0]  STR_SHORT  = 8'h80;
   localparam logic [7:0]  STR_LONG   = 8'hb7;
   localparam logic [7:0]  LIST_SHORT = 8'hc0;
   localparam logic [7:0]  LIST_LONG  = 8'hf7;
   localparam int          INT_BYTES  = 32;
   localparam logic [5:0]  NO_DATA    = 6'd32;
   localparam logic [4:0]  LAST_IDX   = 5'd31;

   // One unit of work for the emitter: an optional prefix byte, then the
   // big-endian bytes of data from index start up to index 31.
   typedef struct packed {
      logic         has_prefix;
      logic [7:0]   prefix;
      logic [5:0]   start;
      logic [255:0] data;
   } desc_type;

   typedef struct packed {
      logic full;
      logic head_valid;
   } q_status_type;

   // Number of zero bytes above the most significant nonzero byte (8 if zero).
   function automatic logic [3:0] lead_zero_bytes(input logic [63:0] w);
      logic [3:0] n;
      n = 4'd8;
      for (int i = 0; i < 8; i++) begin
         if (w[8*i +: 8] != 8'd0) n = 4'(7 - i);
      end
      return n;
   endfunction

endpackage

// File: hdl/rlp_enc_front.sv
// ----------------------------------------------------------------------------
// rlp_enc_front
// Classifies one item into a byte-emission descriptor for the back end.
// ----------------------------------------------------------------------------
module rlp_enc_front
   import rlp_enc_pkg::*;
(
   input  logic [2:0]  op,
   input  logic [63:0] length,
   input  logic [7:0]  data_byte,
   input  logic [63:0] value_word0,
   input  logic [63:0] value_word1,
   input  logic [63:0] value_word2,
   input  logic [63:0] value_word3,
   output logic        emits,
   output desc_type    desc
);

   logic [63:0] w1, w2, w3;
   logic [3:0]  lz0, lz1, lz2, lz3, len_lz;
   logic [5:0]  first;
   logic [7:0]  short_base, long_base;
   desc_type    hdr_desc, int_desc;

   // A 64-bit integer ignores the upper words.
   assign w1 = (op_type'(op) == OP_UINT256) ? value_word1 : 64'd0;
   assign w2 = (op_type'(op) == OP_UINT256) ? value_word2 : 64'd0;
   assign w3 = (op_type'(op) == OP_UINT256) ? value_word3 : 64'd0;

   assign lz0    = lead_zero_bytes(value_word0);
   assign lz1    = lead_zero_bytes(w1);
   assign lz2    = lead_zero_bytes(w2);
   assign lz3    = lead_zero_bytes(w3);
   assign len_lz = lead_zero_bytes(length);

   always_comb begin
      priority if (lz3 != 4'd8) first = 6'(lz3);
      else if (lz2 != 4'd8)     first = 6'd8 + 6'(lz2);
      else if (lz1 != 4'd8)     first = 6'd16 + 6'(lz1);
      else                      first = 6'd24 + 6'(lz0);
   end

   assign short_base = (op_type'(op) == OP_LIST_HDR) ? LIST_SHORT : STR_SHORT;
   assign long_base  = (op_type'(op) == OP_LIST_HDR) ? LIST_LONG : STR_LONG;

   always_comb begin
      hdr_desc = '0;
      hdr_desc.has_prefix = 1'b1;
      if (length <= SHORT_MAX) begin
         hdr_desc.prefix = short_base + length[7:0];
         hdr_desc.start  = NO_DATA;
      end else begin
         hdr_desc.prefix = long_base + 8'(4'd8 - len_lz);
         hdr_desc.start  = 6'd24 + 6'(len_lz);
         hdr_desc.data   = {192'd0, length};
      end
   end

   always_comb begin
      int_desc      = '0;
      int_desc.data = {w3, w2, w1, value_word0};
      priority if (first == NO_DATA) begin
         int_desc.has_prefix = 1'b1;
         int_desc.prefix     = STR_SHORT;
         int_desc.start      = NO_DATA;
      end else if (first == 6'd31 && value_word0[7:0] <= SINGLE_MAX) begin
         int_desc.has_prefix = 1'b0;
         int_desc.start      = first;
      end else begin
         int_desc.has_prefix = 1'b1;
         int_desc.prefix     = STR_SHORT + 8'(NO_DATA - first);
         int_desc.start      = first;
      end
   end

   always_comb begin
      emits = 1'b0;
      desc  = '0;
      unique case (op_type'(op))
         OP_STR_HDR: begin
            emits = !(length == 64'd1 && data_byte <= SINGLE_MAX);
            desc  = hdr_desc;
         end
         OP_LIST_HDR: begin
            emits = 1'b1;
            desc  = hdr_desc;
         end
         OP_PAYLOAD: begin
            emits      = 1'b1;
            desc.start = 6'd31;
            desc.data  = {248'd0, data_byte};
         end
         OP_UINT64, OP_UINT256: begin
            emits = 1'b1;
            desc  = int_desc;
         end
         default: begin
            emits = 1'b0;
            desc  = '0;
         end
      endcase
   end

endmodule

// File: hdl/rlp_enc_queue.sv
// ----------------------------------------------------------------------------
// rlp_enc_queue
// Two-entry descriptor queue between the front and back ends.
// ----------------------------------------------------------------------------
module rlp_enc_queue
   import rlp_enc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  desc_type     push_desc,
   input  logic         pop,
   output q_status_type status,
   output desc_type     head
);

   desc_type   entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign status.full       = (count_ff == 2'd2);
   assign status.head_valid = (count_ff != 2'd0);
   assign head              = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop)      count_in = count_ff + 2'd1;
      else if (!push && pop) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_desc;
   end

endmodule

// File: hdl/rlp_enc_back.sv
// ----------------------------------------------------------------------------
// rlp_enc_back
// Walks the head descriptor and emits one byte per cycle into the output
// register while the output is not stalled.
// ----------------------------------------------------------------------------
module rlp_enc_back
   import rlp_enc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  q_status_type q_status,
   input  desc_type     head,
   output logic         pop,
   input  logic         rsp_stall,
   output logic         rsp_valid,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_last_byte
);

   logic       started_ff;
   logic [4:0] idx_ff;
   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       out_free, fire, emit_prefix, has_data, cur_last;
   logic [4:0] idx;
   logic [7:0] cur_byte, data_sel;

   assign out_free = !valid_ff || !rsp_stall;
   assign fire     = q_status.head_valid && out_free;

   // A fresh descriptor starts at its own index; the prefix goes out first.
   assign idx         = started_ff ? idx_ff : head.start[4:0];
   assign emit_prefix = !started_ff && head.has_prefix;
   assign has_data    = !head.start[5];
   assign data_sel    = head.data[8*(LAST_IDX - idx) +: 8];
   assign cur_byte    = emit_prefix ? head.prefix : data_sel;
   assign cur_last    = emit_prefix ? !has_data : (idx == LAST_IDX);
   assign pop         = fire && cur_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         if (fire) begin
            started_ff <= !cur_last;
         end
         if (out_free) valid_ff <= q_status.head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         idx_ff  <= emit_prefix ? idx : idx + 5'd1;
         byte_ff <= cur_byte;
         last_ff <= cur_last;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_last_byte = last_ff;

endmodule

// File: hdl/rlp_item_encoder.sv
// ----------------------------------------------------------------------------
// rlp_item_encoder
// Serializes RLP items (headers, payload bytes, integers) into a byte stream.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Beat contents
//  req_      in         req_valid/req_stall   op, length, data_byte, value words
//  rsp_      out        rsp_valid/rsp_stall   out_byte, last_byte
//
// A payload item produces one beat and items enter at one per cycle unless
// stalled. A header or integer item produces up to 33 beats, one per cycle
// unless the output stalls, paced by the single byte emitter in the back end;
// the two-entry queue lets the front accept while the emitter is busy. Reset is
// synchronous and clears the queue and the output register. A stalled output
// holds its beat; req_stall rises when the queue is full.
// ----------------------------------------------------------------------------
module rlp_item_encoder
   import rlp_enc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [63:0] req_length,
   input  logic [7:0]  req_data_byte,
   input  logic [63:0] req_value_word0,
   input  logic [63:0] req_value_word1,
   input  logic [63:0] req_value_word2,
   input  logic [63:0] req_value_word3,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_byte
);

   logic         emits, push, pop;
   desc_type     front_desc, head;
   q_status_type q_status;

   rlp_enc_front u_front (
      .op          (req_op),
      .length      (req_length),
      .data_byte   (req_data_byte),
      .value_word0 (req_value_word0),
      .value_word1 (req_value_word1),
      .value_word2 (req_value_word2),
      .value_word3 (req_value_word3),
      .emits       (emits),
      .desc        (front_desc)
   );

   assign req_stall = q_status.full;
   assign push      = req_valid && !req_stall && emits;

   rlp_enc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (front_desc),
      .pop       (pop),
      .status    (q_status),
      .head      (head)
   );

   rlp_enc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .head          (head),
      .pop           (pop),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

// File: hdl/rlp_enc_checker.sv
// ----------------------------------------------------------------------------
// rlp_enc_checker
// Port-level checks of the RLP item encoder, bound to the top level.
// ----------------------------------------------------------------------------
module rlp_enc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_byte
);

   // After reset nothing is queued and nothing is shown.
   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("encoder not empty after reset");

   // A stalled output beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
                                 && $stable(rsp_last_byte))
      else $error("stalled output beat changed");

   // The queue only fills while the emitter already shows a beat.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> rsp_valid)
      else $error("input stalled while output idle");

   // The queue only becomes full right after an accepted item.
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid))
      else $error("input stall rose without an accepted item");

endmodule

bind rlp_item_encoder rlp_enc_checker u_rlp_enc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_last_byte (rsp_last_byte)
);

// File: tb/tb_rlp_item_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rlp_item_encoder
// Self-checking testbench of the RLP item encoder. A queue-fed driver offers
// header, payload and integer items, and an encoding model computes the
// expected byte beats of each accepted item. A monitor compares every output
// beat with the oldest expected beat. The run starts with directed corner
// cases. Random item sequences follow under several idle and stall mixes,
// one of them with a long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_rlp_item_encoder
   import rlp_enc_pkg::*;
();

   localparam int          CLK_HALF      = 5;
   localparam int          RESET_CYCLES  = 11;
   localparam int          CYCLE_LIMIT   = 250000;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          DRAIN_CYCLES  = 20;
   localparam logic [2:0]  OP_UNDEF_LO   = 3'd5;
   localparam logic [2:0]  OP_UNDEF_HI   = 3'd7;

   typedef struct packed {
      logic [2:0]  op;
      logic [63:0] length;
      logic [7:0]  data_byte;
      logic [63:0] w0;
      logic [63:0] w1;
      logic [63:0] w2;
      logic [63:0] w3;
   } rlp_item_type;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } enc_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_op = '0;
   logic [63:0] req_length = '0;
   logic [7:0]  req_data_byte = '0;
   logic [63:0] req_value_word0 = '0;
   logic [63:0] req_value_word1 = '0;
   logic [63:0] req_value_word2 = '0;
   logic [63:0] req_value_word3 = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_byte;

   rlp_item_type pending_items[$];
   enc_beat_type expected_beats[$];
   logic [7:0]   item_bytes[$];
   rlp_item_type offered;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;
   bit hold_start = 1'b0;
   bit hold_seen = 1'b0;
   int cycle_count = 0;
   int errors = 0;
   int items_accepted = 0;
   int beats_checked = 0;
   int header_items = 0;
   int integer_items = 0;
   int payload_items = 0;

   rlp_item_encoder uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_length      (req_length),
      .req_data_byte   (req_data_byte),
      .req_value_word0 (req_value_word0),
      .req_value_word1 (req_value_word1),
      .req_value_word2 (req_value_word2),
      .req_value_word3 (req_value_word3),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

   always #CLK_HALF clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // ---------------------------------------------------------------- model

   function automatic void append_header(logic [63:0] len, logic [7:0] short_base,
                                         logic [7:0] long_base);
      int n;
      if (len <= SHORT_MAX) begin
         item_bytes.push_back(short_base + len[7:0]);
      end else begin
         n = 1;
         while (n < 8 && (len >> (8 * n)) != 64'd0) n++;
         item_bytes.push_back(long_base + 8'(n));
         for (int i = n - 1; i >= 0; i--) item_bytes.push_back(len[8*i +: 8]);
      end
   endfunction

   function automatic void append_integer(logic [255:0] v);
      int n;
      n = 0;
      for (int i = 0; i < INT_BYTES; i++) begin
         if (v[8*i +: 8] != 8'd0) n = i + 1;
      end
      if (n == 0) begin
         item_bytes.push_back(STR_SHORT);
      end else if (n == 1 && v[7:0] <= SINGLE_MAX) begin
         item_bytes.push_back(v[7:0]);
      end else begin
         item_bytes.push_back(STR_SHORT + 8'(n));
         for (int i = n - 1; i >= 0; i--) item_bytes.push_back(v[8*i +: 8]);
      end
   endfunction

   function automatic void encode_item(rlp_item_type it);
      item_bytes.delete();
      case (it.op)
         OP_STR_HDR: begin
            if (!(it.length == 64'd1 && it.data_byte <= SINGLE_MAX))
               append_header(it.length, STR_SHORT, STR_LONG);
         end
         OP_PAYLOAD:  item_bytes.push_back(it.data_byte);
         OP_UINT64:   append_integer({192'd0, it.w0});
         OP_UINT256:  append_integer({it.w3, it.w2, it.w1, it.w0});
         OP_LIST_HDR: append_header(it.length, LIST_SHORT, LIST_LONG);
         default: ;
      endcase
      foreach (item_bytes[i])
         expected_beats.push_back('{value: item_bytes[i], last: (i == item_bytes.size() - 1)});
   endfunction

   // --------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            encode_item(offered);
            items_accepted++;
            case (offered.op)
               OP_STR_HDR, OP_LIST_HDR: header_items++;
               OP_UINT64, OP_UINT256:   integer_items++;
               OP_PAYLOAD:              payload_items++;
               default: ;
            endcase
         end
         if (!req_valid || !req_stall) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               offered = pending_items.pop_front();
               req_op          <= offered.op;
               req_length      <= offered.length;
               req_data_byte   <= offered.data_byte;
               req_value_word0 <= offered.w0;
               req_value_word1 <= offered.w1;
               req_value_word2 <= offered.w2;
               req_value_word3 <= offered.w3;
               req_valid       <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------- monitor

   // The long hold-off runs on its own counter; the stimulus only requests it.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_start != hold_seen) begin
         hold_left <= HOLD_CYCLES;
         hold_seen <= hold_start;
      end
   end

   always @(posedge clock) begin
      enc_beat_type exp_beat;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               $error("unexpected beat: out_byte 8'h%02h last_byte %0d",
                      rsp_out_byte, rsp_last_byte);
               errors++;
            end else begin
               exp_beat = expected_beats.pop_front();
               beats_checked++;
               if (rsp_out_byte !== exp_beat.value) begin
                  $error("out_byte mismatch: expected 8'h%02h, got 8'h%02h",
                         exp_beat.value, rsp_out_byte);
                  errors++;
               end
               if (rsp_last_byte !== exp_beat.last) begin
                  $error("last_byte mismatch: expected %0d, got %0d",
                         exp_beat.last, rsp_last_byte);
                  errors++;
               end
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
      end
   end

   // ------------------------------------------------------------- stimulus

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Unused fields carry random values so that they are seen to be ignored.
   function automatic rlp_item_type make_item(logic [2:0] op);
      rlp_item_type it;
      it.op        = op;
      it.length    = rand64();
      it.data_byte = 8'($urandom);
      it.w0        = rand64();
      it.w1        = rand64();
      it.w2        = rand64();
      it.w3        = rand64();
      return it;
   endfunction

   function automatic logic [63:0] rand_length();
      case ($urandom_range(5))
         0:       return 64'($urandom_range(55));
         1:       return 64'($urandom_range(50, 60));
         2:       return 64'($urandom_range(56, 300));
         3:       return rand64() >> $urandom_range(63);
         4:       return rand64();
         default: return 64'd1;
      endcase
   endfunction

   function automatic rlp_item_type rand_integer();
      rlp_item_type it;
      logic [255:0] v;
      int           nbytes;
      it = make_item($urandom_range(1) ? OP_UINT256 : OP_UINT64);
      v = {rand64(), rand64(), rand64(), rand64()};
      nbytes = (it.op == OP_UINT64) ? $urandom_range(8) : $urandom_range(32);
      if ($urandom_range(4) == 0) begin
         v = 256'($urandom_range(128));
      end else if (nbytes < 32) begin
         v = v & ((256'd1 << (8 * nbytes)) - 256'd1);
      end
      it.w0 = v[63:0];
      if (it.op == OP_UINT256) begin
         it.w1 = v[127:64];
         it.w2 = v[191:128];
         it.w3 = v[255:192];
      end
      return it;
   endfunction

   task automatic add_item(logic [2:0] op, logic [63:0] len, logic [7:0] b,
                           logic [255:0] v);
      rlp_item_type it;
      it = make_item(op);
      it.length    = len;
      it.data_byte = b;
      it.w0        = v[63:0];
      if (op == OP_UINT256) begin
         it.w1 = v[127:64];
         it.w2 = v[191:128];
         it.w3 = v[255:192];
      end
      pending_items.push_back(it);
   endtask

   // Mostly well-formed strings (header then its payload), with integers,
   // list headers, lone payload bytes and fully random noise mixed in.
   task automatic add_random_items(int count);
      rlp_item_type it;
      int           added;
      int           len;
      added = 0;
      while (added < count) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
               len = ($urandom_range(7) == 0) ? $urandom_range(56, 70) : $urandom_range(10);
               it = make_item(OP_STR_HDR);
               it.length = 64'(len);
               pending_items.push_back(it);
               added++;
               for (int i = 0; i < len; i++) begin
                  // A one-byte string reuses the header's first byte.
                  if (!(len == 1 && i == 0)) it = make_item(OP_PAYLOAD);
                  else it.op = OP_PAYLOAD;
                  pending_items.push_back(it);
                  added++;
               end
            end
            5, 6: begin
               pending_items.push_back(rand_integer());
               added++;
            end
            7: begin
               it = make_item(OP_LIST_HDR);
               it.length = rand_length();
               pending_items.push_back(it);
               added++;
            end
            8: begin
               pending_items.push_back(make_item(OP_PAYLOAD));
               added++;
            end
            default: begin
               it = make_item(3'($urandom_range(7)));
               if ($urandom_range(1)) it.length = rand_length();
               pending_items.push_back(it);
               added++;
            end
         endcase
      end
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_valid) @(negedge clock);
      while (expected_beats.size() != 0) @(negedge clock);
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles with %0d beats outstanding",
               cycle_count, expected_beats.size());
      $display("** rlp_item_encoder: FAILED **");
      $finish;
   end

   initial begin : stimulus
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // Directed corners: field extremes, every defined op, both header forms.
      set_idling(0, 0);
      add_item(OP_PAYLOAD,  64'd0, 8'h00, '0);
      add_item(OP_PAYLOAD,  64'd0, 8'hff, '0);
      add_item(OP_STR_HDR,  64'd0, 8'h00, '0);
      add_item(OP_STR_HDR,  64'd1, 8'h7f, '0);
      add_item(OP_STR_HDR,  64'd1, 8'h80, '0);
      add_item(OP_STR_HDR,  64'd55, 8'h00, '0);
      add_item(OP_STR_HDR,  64'd56, 8'h00, '0);
      add_item(OP_STR_HDR,  64'd255, 8'h00, '0);
      add_item(OP_STR_HDR,  64'd256, 8'h00, '0);
      add_item(OP_STR_HDR,  64'h1_0000_0000, 8'h00, '0);
      add_item(OP_STR_HDR,  '1, 8'hff, '0);
      add_item(OP_LIST_HDR, 64'd0, 8'h00, '0);
      add_item(OP_LIST_HDR, 64'd55, 8'h00, '0);
      add_item(OP_LIST_HDR, 64'd56, 8'h00, '0);
      add_item(OP_LIST_HDR, 64'h0100_0000_0000_0000, 8'h00, '0);
      add_item(OP_LIST_HDR, '1, 8'h00, '0);
      add_item(OP_UINT64,   64'd0, 8'h00, 256'd0);
      add_item(OP_UINT64,   64'd0, 8'h00, 256'd1);
      add_item(OP_UINT64,   64'd0, 8'h00, 256'h7f);
      add_item(OP_UINT64,   64'd0, 8'h00, 256'h80);
      add_item(OP_UINT64,   64'd0, 8'h00, {192'd0, 64'hffff_ffff_ffff_ffff});
      add_item(OP_UINT256,  64'd0, 8'h00, 256'd0);
      add_item(OP_UINT256,  64'd0, 8'h00, {8'h01, 248'd0});
      add_item(OP_UINT256,  64'd0, 8'h00, '1);
      add_item(OP_UNDEF_LO, '1, 8'hff, '1);
      add_item(OP_UNDEF_HI, '1, 8'hff, '1);
      wait_drained();

      set_idling(0, 0);
      add_random_items(50);
      wait_drained();

      set_idling(57, 0);
      add_random_items(70);
      wait_drained();

      set_idling(0, 57);
      add_random_items(70);
      wait_drained();

      set_idling(32, 32);
      add_random_items(70);
      wait_drained();

      // The receiver holds off while the sender keeps offering items, so
      // the internal queue fills and req_stall has to rise.
      set_idling(0, 0);
      hold_start = ~hold_start;
      add_random_items(70);
      wait_drained();

      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Covered %0d items (%0d headers, %0d integers, %0d payload bytes)",
               items_accepted, header_items, integer_items, payload_items);
      $display("and %0d output beats across four idle/stall mixes and one long hold-off.",
               beats_checked);
      if (errors == 0) begin
         $display("** rlp_item_encoder: PASSED **");
      end else begin
         $display("** rlp_item_encoder: FAILED **");
      end
      $finish;
   end

endmodule
